/* hw/rtl/bmpu_pkg.sv */
// ----------------------------------------------------------------------------
// bmpu_pkg
// Shared types, constants and helpers for the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package bmpu_pkg;

    localparam int unsigned SIDE_W     = 14;
    localparam int unsigned COMP_W     = 8;
    localparam int unsigned PAL_ADDR_W = 8;
    localparam int unsigned PAL_DATA_W = 3 * COMP_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned S_DATA_W   = 40;
    localparam int unsigned M_DATA_W   = 32;

    localparam logic [COMP_W-1:0] WHITE_MIN    = 8'd220;
    localparam logic [COMP_W-1:0] RED_LOW_MAX  = 8'd20;
    localparam logic [COMP_W-1:0] RED_HIGH_MIN = 8'd220;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRUE_COLOR   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_JOB_MODE     = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        JOB_MILLING = 2'd0,
        JOB_CUTOUT  = 2'd1,
        JOB_BOTH    = 2'd2,
        JOB_SPARE   = 2'd3
    } t_job_mode;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_NO_RED   = 2'd1,
        VERDICT_NO_WHITE = 2'd2,
        VERDICT_RSVD     = 2'd3
    } t_verdict;

    typedef enum logic {
        REQ_PALETTE = 1'b0,
        REQ_PIXEL   = 1'b1
    } t_req;

    // Token handed from the counter stage to the colour stage
    typedef struct packed {
        logic              emit;   // a pixel leaves with this token
        logic              tc;     // components come from the bytes, not the palette
        logic              last;   // final pixel of the image
        logic              clr;    // clear flags once this token is done
        logic [COMP_W-1:0] c0;
        logic [COMP_W-1:0] c1;
        logic [COMP_W-1:0] c2;
    } t_token;

    // Zero means one
    function automatic logic [SIDE_W-1:0] side(input logic [SIDE_W-1:0] v);
        side = (v == '0) ? {{(SIDE_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

/* hw/rtl/bmpu_palette_ram.sv */
// ----------------------------------------------------------------------------
// bmpu_palette_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmpu_palette_ram #(
    parameter int unsigned ADDR_W = 8,
    parameter int unsigned DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data unless a new read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bmp_pixel_unpacker.sv */
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker
// Bitmap pixel-data decoder for 8-bit palette and 24-bit true-colour images.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle on its input stream, whatever
// mix of palette writes, pixel bytes and pad bytes arrives, while the
// output stream does not stall it. A pixel that an accepted item completes
// passes through the registered read of the 256 x 24 palette RAM (the same
// stage is used in 24-bit mode so order is kept), then the output register.
// Row and column counters, the 24-bit byte phase and the pad counter live in
// the first stage; the sticky white and red flags and the verdict are worked
// out in the second stage once the palette colour is known. Palette entries
// are read after they are written; an entry never written returns whatever
// the RAM holds. There is no clearing pass. Input tdata carries entry_index,
// entry_c0, entry_c1, entry_c2 and data_byte from the low byte up; tuser is
// req_type (0 palette write, 1 pixel data byte). Output tdata carries comp0,
// comp1, comp2, seen_red, seen_white and verdict from bit 0 up, and tlast
// marks the image's final pixel. Write the configuration registers only
// while no item is in flight.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bmpu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmpu_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // Input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] entry_index, [15:8] entry_c0, [23:16] entry_c1,
    // [31:24] entry_c2, [39:32] data_byte
    input  logic [bmpu_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [0] req_type
    input  logic                            i_s_tuser,

    // Output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] comp0, [15:8] comp1, [23:16] comp2, [24] seen_red,
    // [25] seen_white, [27:26] verdict, [31:28] zero
    output logic [bmpu_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int unsigned SW = bmpu_pkg::SIDE_W;
    localparam int unsigned CW = bmpu_pkg::COMP_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                  r_tc;
    logic [SW-1:0]         r_width;
    logic [SW-1:0]         r_height;
    bmpu_pkg::t_job_mode   r_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc     <= 1'b0;
            r_width  <= {{(SW-1){1'b0}}, 1'b1};
            r_height <= {{(SW-1){1'b0}}, 1'b1};
            r_job    <= bmpu_pkg::JOB_MILLING;
        end else if (i_cfg_valid) begin
            unique case (bmpu_pkg::t_cfg_reg'(i_cfg_index))
                bmpu_pkg::REG_TRUE_COLOR:   r_tc     <= i_cfg_data[0];
                bmpu_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[SW-1:0];
                bmpu_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[SW-1:0];
                bmpu_pkg::REG_JOB_MODE:     r_job    <= bmpu_pkg::t_job_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking and handshake
    // ------------------------------------------------------------------
    logic [CW-1:0] in_idx, in_c0, in_c1, in_c2, in_byte;
    logic          in_acc, in_pal, in_pix;
    logic          r_s1_vld;
    bmpu_pkg::t_token r_s1;
    logic          s1_move;
    logic          r_out_vld;

    assign in_idx  = i_s_tdata[7:0];
    assign in_c0   = i_s_tdata[15:8];
    assign in_c1   = i_s_tdata[23:16];
    assign in_c2   = i_s_tdata[31:24];
    assign in_byte = i_s_tdata[39:32];

    // The colour stage drains when the output register is empty or taken
    assign s1_move    = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_move;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign in_pal     = in_acc && (bmpu_pkg::t_req'(i_s_tuser) == bmpu_pkg::REQ_PALETTE);
    assign in_pix     = in_acc && (bmpu_pkg::t_req'(i_s_tuser) == bmpu_pkg::REQ_PIXEL);

    // ------------------------------------------------------------------
    // Counter stage
    // ------------------------------------------------------------------
    logic [SW-1:0] r_col, n_col;
    logic [SW-1:0] r_row, n_row;
    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_pad, n_pad;
    logic [CW-1:0] r_part0, n_part0;
    logic [CW-1:0] r_part1, n_part1;

    logic [SW-1:0] w_eff, h_eff;
    logic          row_end, row_last, is_last_row;
    logic [1:0]    row_bytes_lsb, row_pad;
    logic          pix_done, pal_rd;
    bmpu_pkg::t_token tok;

    assign w_eff       = bmpu_pkg::side(r_width);
    assign h_eff       = bmpu_pkg::side(r_height);
    assign row_end     = ({1'b0, r_col} + {{SW{1'b0}}, 1'b1}) >= {1'b0, w_eff};
    assign is_last_row = ({1'b0, r_row} + {{SW{1'b0}}, 1'b1}) >= {1'b0, h_eff};
    assign row_last    = row_end && is_last_row;

    // Bytes per row mod 4, then the bytes needed to reach the next multiple
    assign row_bytes_lsb = r_tc ? 2'(w_eff[1:0] + {w_eff[1:0], 1'b0}) : w_eff[1:0];
    assign row_pad       = 2'd0 - row_bytes_lsb;

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_phase  = r_phase;
        n_pad    = r_pad;
        n_part0  = r_part0;
        n_part1  = r_part1;
        pix_done = 1'b0;
        pal_rd   = 1'b0;
        tok      = '{emit: 1'b0, tc: r_tc, last: 1'b0, clr: 1'b0,
                     c0: r_part0, c1: r_part1, c2: in_byte};

        if (in_pix) begin
            priority if (r_pad != 2'd0) begin
                // Drop a pad byte; the last one closes the row
                n_pad = r_pad - 2'd1;
                if (r_pad == 2'd1) begin
                    n_col = '0;
                    if (is_last_row) begin
                        n_row   = '0;
                        tok.clr = 1'b1;
                    end else begin
                        n_row = r_row + {{(SW-1){1'b0}}, 1'b1};
                    end
                end
            end else if (!r_tc) begin
                n_phase  = 2'd0;
                pal_rd   = 1'b1;
                pix_done = 1'b1;
            end else if (r_phase == 2'd0) begin
                n_part0 = in_byte;
                n_phase = 2'd1;
            end else if (r_phase == 2'd1) begin
                n_part1 = in_byte;
                n_phase = 2'd2;
            end else begin
                n_phase  = 2'd0;
                pix_done = 1'b1;
            end

            if (pix_done) begin
                tok.emit = 1'b1;
                tok.last = row_last;
                if (row_end) begin
                    n_pad = row_pad;
                    if (row_pad == 2'd0) begin
                        n_col = '0;
                        if (is_last_row) begin
                            n_row   = '0;
                            tok.clr = 1'b1;
                        end else begin
                            n_row = r_row + {{(SW-1){1'b0}}, 1'b1};
                        end
                    end
                end else begin
                    n_col = r_col + {{(SW-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= 2'd0;
            r_pad   <= 2'd0;
            r_part0 <= '0;
            r_part1 <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_part0 <= n_part0;
            r_part1 <= n_part1;
        end
    end

    // ------------------------------------------------------------------
    // Palette RAM: written by palette items, read by 8-bit pixel bytes
    // ------------------------------------------------------------------
    logic [bmpu_pkg::PAL_DATA_W-1:0] pal_q;

    bmpu_palette_ram #(
        .ADDR_W (bmpu_pkg::PAL_ADDR_W),
        .DATA_W (bmpu_pkg::PAL_DATA_W)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (in_pal),
        .i_waddr (in_idx),
        .i_wdata ({in_c2, in_c1, in_c0}),
        .i_re    (pal_rd),
        .i_raddr (in_byte),
        .o_rdata (pal_q)
    );

    // Each completed pixel and each image-closing pad byte enters the colour stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= tok.emit || tok.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_s1 <= tok;
        end
    end

    // ------------------------------------------------------------------
    // Colour stage: flags and verdict
    // ------------------------------------------------------------------
    logic          r_red, r_white;
    logic [CW-1:0] px0, px1, px2;
    logic          is_white, is_red, red_new, white_new;
    bmpu_pkg::t_verdict verdict;

    assign px0 = r_s1.tc ? r_s1.c0 : pal_q[CW-1:0];
    assign px1 = r_s1.tc ? r_s1.c1 : pal_q[2*CW-1:CW];
    assign px2 = r_s1.tc ? r_s1.c2 : pal_q[3*CW-1:2*CW];

    assign is_white  = (px0 > bmpu_pkg::WHITE_MIN) && (px1 > bmpu_pkg::WHITE_MIN)
                       && (px2 > bmpu_pkg::WHITE_MIN);
    assign is_red    = r_s1.tc && (px0 < bmpu_pkg::RED_LOW_MAX)
                       && (px1 < bmpu_pkg::RED_LOW_MAX) && (px2 > bmpu_pkg::RED_HIGH_MIN);
    assign red_new   = r_red || is_red;
    assign white_new = r_white || is_white;

    always_comb begin
        verdict = bmpu_pkg::VERDICT_OK;
        if (r_s1.last) begin
            priority if (r_job == bmpu_pkg::JOB_BOTH && !red_new) begin
                verdict = bmpu_pkg::VERDICT_NO_RED;
            end else if (!white_new) begin
                verdict = bmpu_pkg::VERDICT_NO_WHITE;
            end else begin
                verdict = bmpu_pkg::VERDICT_OK;
            end
        end
    end

    // Flags follow each token in order; clear after the image's closing token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= 1'b0;
            r_white <= 1'b0;
        end else if (s1_move) begin
            if (r_s1.clr) begin
                r_red   <= 1'b0;
                r_white <= 1'b0;
            end else if (r_s1.emit) begin
                r_red   <= red_new;
                r_white <= white_new;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [bmpu_pkg::M_DATA_W-1:0] r_out_data;
    logic                          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= r_s1.emit;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1.emit) begin
            r_out_data <= {4'b0000, verdict, white_new, red_new, px2, px1, px0};
            r_out_last <= r_s1.last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pad_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != 2'd0) |-> (r_phase == 2'd0))
        else $error("pad bytes pending with a partial pixel");

    a_flag_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1.clr) |=> (!r_red && !r_white))
        else $error("flags not cleared at image end");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[27:26] == bmpu_pkg::VERDICT_OK))
        else $error("verdict set off the last pixel");

    a_clear_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && tok.clr) |=> (r_row == '0 && r_col == '0))
        else $error("counters not cleared at image end");

endmodule

/* test/tb_bmp_pixel_unpacker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_pixel_unpacker
// Self-checking bench for the bitmap pixel-data decoder.
// ----------------------------------------------------------------------------
// A directed table covers reset defaults, white and red thresholds, every job
// mode, zero width, a register change part-way through an image and a switch
// from 24-bit to 8-bit between bytes of one pixel. Random images follow,
// mostly well formed and some cut short, with palette writes mixed in. Every
// accepted item runs through a local decoder model; its pixels are queued and
// compared field by field with what leaves the output stream.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_unpacker;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 60;
    localparam int PHASE_ITEMS     = 185;
    localparam int MAX_REPORTS     = 40;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DIR_ROWS        = 37;
    localparam int MAX_IMAGE_BYTES = 256;

    // One decoded pixel as it leaves the block
    typedef struct packed {
        logic [7:0]         c0;
        logic [7:0]         c1;
        logic [7:0]         c2;
        logic               last;
        logic               red;
        logic               white;
        bmpu_pkg::t_verdict verdict;
    } t_pixel;

    // Directed table: a register write, a palette entry or a pixel-area byte
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PAL,
        ROW_PIX
    } t_row_kind;

    // csr and a: register and value for ROW_CFG; a[7:0] is the slot for
    // ROW_PAL and the byte for ROW_PIX
    typedef struct packed {
        t_row_kind          kind;
        bmpu_pkg::t_cfg_reg csr;
        logic [13:0]        a;
        logic [7:0]         c0;
        logic [7:0]         c1;
        logic [7:0]         c2;
        logic               typed;
        t_pixel             want;
    } t_dir_row;

    localparam t_pixel NO_PX = '0;

    // ------------------------------------------------------------------------
    // DUT connections, inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [bmpu_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [bmpu_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            i_s_tvalid  = 1'b0;
    logic                            o_s_tready;
    logic [bmpu_pkg::S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                            i_s_tuser   = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready  = 1'b0;
    logic [bmpu_pkg::M_DATA_W-1:0]   o_m_tdata;
    logic                            o_m_tlast;

    bmp_pixel_unpacker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Decoder model state and configuration shadow
    // ------------------------------------------------------------------------
    logic [23:0] pal_mem [256];
    bit          pal_written [256];
    int          pal_used [$];         // slots safe to read in 8-bit mode
    int          col_cnt    = 0;
    int          row_cnt    = 0;
    int          pad_left   = 0;
    int          byte_phase = 0;
    logic [15:0] part_px    = '0;
    bit          red_seen   = 1'b0;
    bit          white_seen = 1'b0;

    logic                tc_cfg     = 1'b0;
    logic [13:0]         width_cfg  = 14'd1;
    logic [13:0]         height_cfg = 14'd1;
    bmpu_pkg::t_job_mode mode_cfg   = bmpu_pkg::JOB_MILLING;

    t_pixel      pending_pixels [$];

    // Bench control
    int  src_idle    = 0;              // percent of items preceded by a gap
    int  snk_idle    = 0;              // percent of cycles with tready low
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  n_items     = 0;
    int  n_err       = 0;
    int  idle_cycles = 0;
    t_pixel mon_want;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic int eff_side(input logic [13:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Pad bytes that bring one row to a multiple of four
    function automatic int row_pad_bytes(input int w);
        int bytes;
        bytes = tc_cfg ? 3 * w : w;
        return (4 - (bytes % 4)) % 4;
    endfunction

    // Advance to the next row; wrap and clear the flags at image end
    task automatic next_row_model();
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= eff_side(height_cfg)) begin
            row_cnt    = 0;
            red_seen   = 1'b0;
            white_seen = 1'b0;
        end
    endtask

    task automatic emit_model(input logic [7:0] c0, c1, c2);
        int     w;
        int     h;
        bit     row_end;
        t_pixel px;
        w       = eff_side(width_cfg);
        h       = eff_side(height_cfg);
        row_end = (col_cnt + 1 >= w);
        if (c0 > bmpu_pkg::WHITE_MIN && c1 > bmpu_pkg::WHITE_MIN
            && c2 > bmpu_pkg::WHITE_MIN)
            white_seen = 1'b1;
        if (tc_cfg && c0 < bmpu_pkg::RED_LOW_MAX && c1 < bmpu_pkg::RED_LOW_MAX
            && c2 > bmpu_pkg::RED_HIGH_MIN)
            red_seen = 1'b1;
        px.c0      = c0;
        px.c1      = c1;
        px.c2      = c2;
        px.last    = row_end && (row_cnt + 1 >= h);
        px.red     = red_seen;
        px.white   = white_seen;
        px.verdict = bmpu_pkg::VERDICT_OK;
        // Verdict only on the final pixel; red takes precedence in both mode
        if (px.last) begin
            if (mode_cfg == bmpu_pkg::JOB_BOTH && !red_seen)
                px.verdict = bmpu_pkg::VERDICT_NO_RED;
            else if (!white_seen)
                px.verdict = bmpu_pkg::VERDICT_NO_WHITE;
        end
        pending_pixels.push_back(px);
        if (row_end) begin
            pad_left = row_pad_bytes(w);
            if (pad_left == 0)
                next_row_model();
        end else begin
            col_cnt++;
        end
    endtask

    // Apply one accepted item to the model, queueing any pixel it completes
    task automatic unpack_step(input bmpu_pkg::t_req req, input logic [7:0] idx,
                               c0, c1, c2, input logic [7:0] dbyte);
        if (req == bmpu_pkg::REQ_PALETTE) begin
            if (!pal_written[idx]) begin
                pal_written[idx] = 1'b1;
                pal_used.push_back(int'(idx));
            end
            pal_mem[idx] = {c2, c1, c0};
        end else if (pad_left != 0) begin
            pad_left--;
            if (pad_left == 0)
                next_row_model();
        end else if (!tc_cfg) begin
            byte_phase = 0;
            emit_model(pal_mem[dbyte][7:0], pal_mem[dbyte][15:8], pal_mem[dbyte][23:16]);
        end else if (byte_phase == 0) begin
            part_px[7:0] = dbyte;
            byte_phase   = 1;
        end else if (byte_phase == 1) begin
            part_px[15:8] = dbyte;
            byte_phase    = 2;
        end else begin
            byte_phase = 0;
            emit_model(part_px[7:0], part_px[15:8], dbyte);
        end
    endtask

    task automatic apply_csr(input bmpu_pkg::t_cfg_reg csr, input logic [13:0] val);
        case (csr)
            bmpu_pkg::REG_TRUE_COLOR:   tc_cfg     = val[0];
            bmpu_pkg::REG_IMAGE_WIDTH:  width_cfg  = val;
            bmpu_pkg::REG_IMAGE_HEIGHT: height_cfg = val;
            bmpu_pkg::REG_JOB_MODE:     mode_cfg   = bmpu_pkg::t_job_mode'(val[1:0]);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Drivers: every task starts and ends just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(input bmpu_pkg::t_req req, input logic [7:0] idx,
                             c0, c1, c2, input logic [7:0] dbyte, input bit typed,
                             input t_pixel want);
        int n;
        while ($urandom_range(0, 99) < src_idle) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = req;
        i_s_tdata  = {dbyte, c2, c1, c0, idx};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        n = pending_pixels.size();
        unpack_step(req, idx, c0, c1, c2, dbyte);
        // Rows with a hand-written result replace what the model gave
        if (typed && pending_pixels.size() > n)
            pending_pixels[pending_pixels.size() - 1] = want;
        n_items++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    // Hold until every pixel is out, then let the pipeline settle
    task automatic drain_pixels();
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_csr(input bmpu_pkg::t_cfg_reg csr, input logic [13:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = csr;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_csr(csr, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Component values biased towards the white and red thresholds
    function automatic logic [7:0] rnd_comp();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 19));
            1: return 8'($urandom_range(221, 255));
            2: return ($urandom_range(0, 1) ? 8'd19 : 8'd20) +
                      ($urandom_range(0, 1) ? 8'd201 : 8'd0);
            3: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_palette_entry();
        send_item(bmpu_pkg::REQ_PALETTE, 8'($urandom), rnd_comp(), rnd_comp(), rnd_comp(),
                  8'($urandom), 1'b0, NO_PX);
    endtask

    // Next byte of the pixel area: pad bytes are free, 8-bit indices only
    // point at written slots, 24-bit bytes lean on the colour thresholds
    task automatic feed_next();
        logic [7:0] b;
        if (pad_left != 0)
            b = 8'($urandom);
        else if (tc_cfg)
            b = rnd_comp();
        else
            b = 8'(pal_used[$urandom_range(0, pal_used.size() - 1)]);
        send_item(bmpu_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), b, 1'b0, NO_PX);
    endtask

    task automatic random_config();
        int r;
        drain_pixels();
        write_csr(bmpu_pkg::REG_TRUE_COLOR, 14'($urandom_range(0, 1)));
        r = $urandom_range(0, 9);
        if (r == 0)
            write_csr(bmpu_pkg::REG_IMAGE_WIDTH, 14'd0);
        else if (r == 9)
            write_csr(bmpu_pkg::REG_IMAGE_WIDTH, 14'($urandom_range(7, 20)));
        else
            write_csr(bmpu_pkg::REG_IMAGE_WIDTH, 14'($urandom_range(1, 6)));
        write_csr(bmpu_pkg::REG_IMAGE_HEIGHT, 14'($urandom_range(0, 3)));
        write_csr(bmpu_pkg::REG_JOB_MODE, 14'($urandom_range(0, 3)));
    endtask

    function automatic int image_bytes();
        int w;
        w = eff_side(width_cfg);
        return ((tc_cfg ? 3 * w : w) + row_pad_bytes(w)) * eff_side(height_cfg);
    endfunction

    // Mostly whole images with random content; some cut short, some noise
    task automatic run_phase(input int src_pct, input int snk_pct, input int target);
        int first;
        int r;
        int cnt;
        src_idle = src_pct;
        snk_idle = snk_pct;
        first    = n_items;
        while (n_items - first < target) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                // Leave a huge image behind before feeding a whole one
                if ($urandom_range(0, 1) || image_bytes() > MAX_IMAGE_BYTES)
                    random_config();
                if (!tc_cfg)
                    repeat ($urandom_range(0, 3)) write_palette_entry();
                cnt = image_bytes();
                if ($urandom_range(0, 6) == 0)
                    cnt = $urandom_range(1, cnt);
                repeat (cnt) begin
                    if ($urandom_range(0, 11) == 0)
                        write_palette_entry();
                    feed_next();
                end
            end else if (r < 90) begin
                repeat ($urandom_range(1, 6)) feed_next();
            end else begin
                repeat ($urandom_range(1, 3)) write_palette_entry();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off counted here
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = ($urandom_range(0, 99) >= snk_idle);
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        n_err++;
        if (n_err <= MAX_REPORTS)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with nothing expected, tdata", o_m_tdata, 0);
            end else begin
                mon_want = pending_pixels.pop_front();
                if (o_m_tdata[7:0] !== mon_want.c0)
                    report_mismatch("comp0", o_m_tdata[7:0], mon_want.c0);
                if (o_m_tdata[15:8] !== mon_want.c1)
                    report_mismatch("comp1", o_m_tdata[15:8], mon_want.c1);
                if (o_m_tdata[23:16] !== mon_want.c2)
                    report_mismatch("comp2", o_m_tdata[23:16], mon_want.c2);
                if (o_m_tlast !== mon_want.last)
                    report_mismatch("last_pixel", o_m_tlast, mon_want.last);
                if (o_m_tdata[24] !== mon_want.red)
                    report_mismatch("seen_red", o_m_tdata[24], mon_want.red);
                if (o_m_tdata[25] !== mon_want.white)
                    report_mismatch("seen_white", o_m_tdata[25], mon_want.white);
                if (o_m_tdata[27:26] !== mon_want.verdict)
                    report_mismatch("verdict", o_m_tdata[27:26], mon_want.verdict);
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind completes for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    t_dir_row dir_tab [DIR_ROWS] = '{
        // Palette: black, full white, just white, just short of white
        '{ROW_PAL, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0,   8'd0,   8'd0,   1'b0, NO_PX},
        '{ROW_PAL, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd255, 8'd255, 8'd255, 1'b0, NO_PX},
        '{ROW_PAL, bmpu_pkg::REG_TRUE_COLOR, 14'd170, 8'd221, 8'd221, 8'd221, 1'b0, NO_PX},
        '{ROW_PAL, bmpu_pkg::REG_TRUE_COLOR, 14'd85,  8'd220, 8'd255, 8'd255, 1'b0, NO_PX},
        // Reset sizes: one 8-bit pixel is the whole image, three pad bytes
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b1,
          '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, bmpu_pkg::VERDICT_NO_WHITE}},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        // Width four needs no padding; both mode without red
        '{ROW_CFG, bmpu_pkg::REG_IMAGE_WIDTH, 14'd4,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_JOB_MODE, 14'(bmpu_pkg::JOB_BOTH),
          8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd170, 8'd0, 8'd0, 8'd0, 1'b1,
          '{8'd221, 8'd221, 8'd221, 1'b0, 1'b0, 1'b1, bmpu_pkg::VERDICT_OK}},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd85,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b1,
          '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, bmpu_pkg::VERDICT_NO_RED}},
        // 24-bit, zero width taken as one, spare mode follows milling
        '{ROW_CFG, bmpu_pkg::REG_TRUE_COLOR, 14'd1,   8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_IMAGE_WIDTH, 14'd0,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_JOB_MODE, 14'(bmpu_pkg::JOB_SPARE),
          8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd19,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd19,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd221, 8'd0, 8'd0, 8'd0, 1'b1,
          '{8'd19, 8'd19, 8'd221, 1'b1, 1'b1, 1'b0, bmpu_pkg::VERDICT_NO_WHITE}},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        // Cutout, 2x2, then shrink the width part-way through the first row
        '{ROW_CFG, bmpu_pkg::REG_JOB_MODE, 14'(bmpu_pkg::JOB_CUTOUT),
          8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_IMAGE_WIDTH, 14'd2,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_IMAGE_HEIGHT, 14'd2, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd20,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_IMAGE_WIDTH, 14'd1,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        // Drop to 8-bit with one byte of a 24-bit pixel held
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_TRUE_COLOR, 14'd0,   8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_PIX, bmpu_pkg::REG_TRUE_COLOR, 14'd255, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        // Largest sizes; the random part starts inside such an image
        '{ROW_CFG, bmpu_pkg::REG_IMAGE_WIDTH, 14'd16383,  8'd0, 8'd0, 8'd0, 1'b0, NO_PX},
        '{ROW_CFG, bmpu_pkg::REG_IMAGE_HEIGHT, 14'd16383, 8'd0, 8'd0, 8'd0, 1'b0, NO_PX}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_dir_row step_row;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part runs under the first idling pattern
        src_idle = 21;
        snk_idle = 52;
        for (int i = 0; i < DIR_ROWS; i++) begin
            step_row = dir_tab[i];
            case (step_row.kind)
                ROW_CFG: begin
                    drain_pixels();
                    write_csr(step_row.csr, step_row.a);
                end
                ROW_PAL: begin
                    send_item(bmpu_pkg::REQ_PALETTE, step_row.a[7:0], step_row.c0,
                              step_row.c1, step_row.c2, 8'($urandom), 1'b0, NO_PX);
                end
                default: begin
                    send_item(bmpu_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), step_row.a[7:0],
                              step_row.typed, step_row.want);
                end
            endcase
        end

        // Part of the huge image's first row before the random images take over
        repeat (12) feed_next();

        run_phase(21, 52, PHASE_ITEMS);
        run_phase(52, 21, PHASE_ITEMS);

        // Long receiver hold-off with the sender flat out: fill the block
        src_idle = 0;
        snk_idle = 0;
        drain_pixels();
        write_csr(bmpu_pkg::REG_TRUE_COLOR, 14'd0);
        hold_req = 1'b1;
        repeat (40) feed_next();
        run_phase(0, 0, PHASE_ITEMS);

        // Wait out the last pixels, then give stragglers time to show up
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
